/* rtl/core/vus_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants of the utterance segmenter
// no dependencies

package vus_pkg;

  localparam int PREROLL_DEPTH_DEF = 64;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // register indexes, taken from paddr[4:2]
  localparam logic [2:0] REG_START_RUN     = 3'd0;
  localparam logic [2:0] REG_PREROLL       = 3'd1;
  localparam logic [2:0] REG_SILENCE_CLOSE = 3'd2;
  localparam logic [2:0] REG_MIN_SPEECH    = 3'd3;
  localparam logic [2:0] REG_MAX_LENGTH    = 3'd4;

  // close reasons
  localparam logic [1:0] REASON_SILENCE = 2'd0;
  localparam logic [1:0] REASON_MAX_LEN = 2'd1;
  localparam logic [1:0] REASON_EOS     = 2'd2;

  localparam logic [6:0] RUN_MAX = 7'd127;
  localparam logic [15:0] CNT16_MAX = 16'hFFFF;

  typedef struct packed {
    logic [15:0] speech_count;
    logic [15:0] frame_total;
    logic [31:0] end_frame;
    logic [31:0] start_frame;
    logic [31:0] utt_id;
    logic [1:0]  close_reason;
    logic        kept;
  } result_t;

endpackage

/* rtl/core/vus_ram.sv */
`timescale 1ns / 1ps
// generic single-write, single-read ram with registered read (old data on collision)
// no dependencies

module vus_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/vad_utterance_segmenter.sv */
`timescale 1ns / 1ps
// top level of the voice-activity utterance segmenter
// depends on vus_pkg and vus_ram
//
// usage:
//   in_*  : one event per beat; in_tuser[0] = cmd (0 frame, 1 end of stream),
//           in_tdata[0] = speech flag of the frame
//   out_* : one beat per closed utterance (kept or discarded as too short)
//   cfg_* : apb register port, five registers at byte address 4*i, pready tied high
// throughput: one event per clock while the output queue has room; the pre-roll
//   ring's oldest flag is prefetched from the ram each cycle at the next head
//   address, with a forward path when the same entry is written in that cycle
// a result is registered into the output queue, so out_tvalid is high in the cycle after the event that closes it
// a two-entry output queue sits before out_*; events keep being taken while
//   one result waits, and in_tready drops only when both entries are full
// reset: all control and counters clear, mode idle, registers take their
//   defaults; the ring ram is not cleared (entries are read only after a write),
//   so no clearing pass is needed and events are taken right after reset
// after an end-of-stream event every further event is taken and ignored until reset

module vad_utterance_segmenter #(
  parameter int PREROLL_DEPTH = vus_pkg::PREROLL_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // input stream
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [0] speech flag
  input  logic [0:0]                 in_tuser,   // [0] cmd
  // result stream
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // [31:0] utt_id, [63:32] start_frame, [95:64] end_frame,
  // [111:96] frame_total, [127:112] speech_count
  output logic [127:0]               out_tdata,
  output logic [2:0]                 out_tuser,  // [0] kept, [2:1] close_reason
  // configuration
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [vus_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [vus_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [vus_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);

  localparam int AW = (PREROLL_DEPTH > 1) ? $clog2(PREROLL_DEPTH) : 1;
  localparam int FW = $clog2(PREROLL_DEPTH + 1);
  localparam int CW = (FW > 7) ? FW : 7;
  localparam int SW = ((AW > FW) ? AW : FW) + 1;

  typedef enum logic [1:0] {MODE_IDLE, MODE_SPEECH, MODE_ENDING} mode_t;

  // configuration registers
  logic [6:0]  start_run_r, preroll_frames_r;
  logic [15:0] silence_close_r, min_speech_r, max_length_r;

  // segmenter state
  mode_t       mode_r, mode_nxt;
  logic        ended_r, ended_nxt;
  logic [6:0]  speech_run_r, speech_run_nxt;
  logic [15:0] silence_run_r, silence_run_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [FW-1:0] fill_r, fill_nxt;
  logic [FW-1:0] pspeech_r, pspeech_nxt;
  logic [15:0] utt_frames_r, utt_frames_nxt;
  logic [15:0] utt_speech_r, utt_speech_nxt;
  logic [31:0] utt_start_r, utt_start_nxt;
  logic [31:0] frame_index_r, frame_index_nxt;
  logic [31:0] next_id_r, next_id_nxt;

  // ring ram and forward path
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic          ram_rdata;
  logic          fwd_hit_r;
  logic          fwd_data_r;
  logic          oldest_flag;

  // output queue
  vus_pkg::result_t slot0_r, slot1_r;
  logic [1:0]  cnt_r, cnt_nxt;
  vus_pkg::result_t res;
  logic        push, pop;

  logic        in_fire, cmd, is_sp;
  logic        close_ev;
  logic [1:0]  close_reason;
  logic [6:0]  need, run_inc;
  logic [CW-1:0] cap, fill_ext;
  logic [SW-1:0] wsum;
  logic        keep;
  logic        cfg_wr;

  assign in_fire = in_tvalid && in_tready;
  assign cmd     = in_tuser[0];
  assign is_sp   = in_tdata[0];
  assign pop     = out_tvalid && out_tready;
  assign in_tready = (cnt_r != 2'd2);

  assign oldest_flag = fwd_hit_r ? fwd_data_r : ram_rdata;

  assign need     = (start_run_r == 7'd0) ? 7'd1 : start_run_r;
  assign fill_ext = CW'(fill_r);
  assign cap = (CW'(preroll_frames_r) > CW'(PREROLL_DEPTH)) ? CW'(PREROLL_DEPTH)
                                                            : CW'(preroll_frames_r);

  always_comb begin
    wsum = SW'(head_r) + SW'(fill_r);
    if (wsum >= SW'(PREROLL_DEPTH)) begin
      wsum = wsum - SW'(PREROLL_DEPTH);
    end
  end

  always_comb begin
    mode_nxt        = mode_r;
    ended_nxt       = ended_r;
    speech_run_nxt  = speech_run_r;
    silence_run_nxt = silence_run_r;
    head_nxt        = head_r;
    fill_nxt        = fill_r;
    pspeech_nxt     = pspeech_r;
    utt_frames_nxt  = utt_frames_r;
    utt_speech_nxt  = utt_speech_r;
    utt_start_nxt   = utt_start_r;
    frame_index_nxt = frame_index_r;
    next_id_nxt     = next_id_r;
    close_ev        = 1'b0;
    close_reason    = vus_pkg::REASON_SILENCE;
    ram_we          = 1'b0;
    ram_waddr       = AW'(wsum);
    ram_wdata       = is_sp;
    run_inc         = 7'd0;

    if (in_fire && !ended_r) begin
      if (cmd) begin
        ended_nxt = 1'b1;
        if (mode_r != MODE_IDLE) begin
          close_ev     = 1'b1;
          close_reason = vus_pkg::REASON_EOS;
        end
      end else begin
        frame_index_nxt = frame_index_r + 32'd1;
        case (mode_r)
          MODE_IDLE: begin
            if (is_sp) begin
              run_inc = (speech_run_r == vus_pkg::RUN_MAX) ? speech_run_r
                                                           : speech_run_r + 7'd1;
            end
            if (run_inc >= need) begin
              // utterance opens with the pre-roll plus this frame
              utt_start_nxt   = frame_index_r - 32'(fill_r);
              utt_frames_nxt  = 16'(fill_r) + 16'd1;
              utt_speech_nxt  = 16'(pspeech_r) + 16'd1;
              head_nxt        = '0;
              fill_nxt        = '0;
              pspeech_nxt     = '0;
              speech_run_nxt  = 7'd0;
              silence_run_nxt = 16'd0;
              mode_nxt        = MODE_SPEECH;
              if (utt_frames_nxt >= max_length_r) begin
                close_ev     = 1'b1;
                close_reason = vus_pkg::REASON_MAX_LEN;
              end
            end else begin
              speech_run_nxt = run_inc;
              if (fill_ext >= cap) begin
                if (fill_r != '0) begin
                  // full ring: drop the oldest flag, store the new one
                  pspeech_nxt = pspeech_r - FW'(oldest_flag) + FW'(is_sp);
                  head_nxt    = (head_r == AW'(PREROLL_DEPTH - 1)) ? '0 : head_r + AW'(1);
                  ram_we      = 1'b1;
                end
              end else begin
                fill_nxt    = fill_r + FW'(1);
                pspeech_nxt = pspeech_r + FW'(is_sp);
                ram_we      = 1'b1;
              end
            end
          end
          MODE_SPEECH, MODE_ENDING: begin
            if (utt_frames_r != vus_pkg::CNT16_MAX) begin
              utt_frames_nxt = utt_frames_r + 16'd1;
            end
            if (is_sp && utt_speech_r != vus_pkg::CNT16_MAX) begin
              utt_speech_nxt = utt_speech_r + 16'd1;
            end
            if (is_sp) begin
              silence_run_nxt = 16'd0;
              mode_nxt        = MODE_SPEECH;
            end else begin
              if (mode_r == MODE_SPEECH) begin
                silence_run_nxt = 16'd1;
              end else if (silence_run_r != vus_pkg::CNT16_MAX) begin
                silence_run_nxt = silence_run_r + 16'd1;
              end
              mode_nxt = MODE_ENDING;
            end
            // end silence wins over max length
            if (!is_sp && silence_run_nxt >= silence_close_r) begin
              close_ev     = 1'b1;
              close_reason = vus_pkg::REASON_SILENCE;
            end else if (utt_frames_nxt >= max_length_r) begin
              close_ev     = 1'b1;
              close_reason = vus_pkg::REASON_MAX_LEN;
            end
          end
          default: begin
            mode_nxt = MODE_IDLE;
          end
        endcase
      end
    end

    keep = (utt_speech_nxt >= min_speech_r);
    res.kept         = keep;
    res.close_reason = close_reason;
    res.utt_id       = keep ? next_id_r : 32'd0;
    res.start_frame  = utt_start_nxt;
    res.end_frame    = frame_index_nxt - 32'd1;
    res.frame_total  = utt_frames_nxt;
    res.speech_count = utt_speech_nxt;
    push = close_ev;

    if (close_ev) begin
      if (keep) begin
        next_id_nxt = next_id_r + 32'd1;
      end
      utt_frames_nxt  = 16'd0;
      utt_speech_nxt  = 16'd0;
      silence_run_nxt = 16'd0;
      speech_run_nxt  = 7'd0;
      head_nxt        = '0;
      fill_nxt        = '0;
      pspeech_nxt     = '0;
      mode_nxt        = MODE_IDLE;
    end
  end

  assign cnt_nxt = cnt_r + 2'(push) - 2'(pop);

  // the ram is always read at the head the ring will have next cycle
  vus_ram #(
    .WIDTH (1),
    .DEPTH (PREROLL_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (head_nxt),
    .rdata (ram_rdata)
  );

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_run_r      <= 7'd3;
      preroll_frames_r <= 7'd10;
      silence_close_r  <= 16'd25;
      min_speech_r     <= 16'd10;
      max_length_r     <= 16'd1500;
      mode_r           <= MODE_IDLE;
      ended_r          <= 1'b0;
      speech_run_r     <= 7'd0;
      silence_run_r    <= 16'd0;
      head_r           <= '0;
      fill_r           <= '0;
      pspeech_r        <= '0;
      utt_frames_r     <= 16'd0;
      utt_speech_r     <= 16'd0;
      utt_start_r      <= 32'd0;
      frame_index_r    <= 32'd0;
      next_id_r        <= 32'd0;
      fwd_hit_r        <= 1'b0;
      fwd_data_r       <= 1'b0;
      cnt_r            <= 2'd0;
    end else begin
      if (cfg_wr) begin
        case (cfg_paddr[4:2])
          vus_pkg::REG_START_RUN:     start_run_r      <= cfg_pwdata[6:0];
          vus_pkg::REG_PREROLL:       preroll_frames_r <= cfg_pwdata[6:0];
          vus_pkg::REG_SILENCE_CLOSE: silence_close_r  <= cfg_pwdata[15:0];
          vus_pkg::REG_MIN_SPEECH:    min_speech_r     <= cfg_pwdata[15:0];
          vus_pkg::REG_MAX_LENGTH:    max_length_r     <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      mode_r        <= mode_nxt;
      ended_r       <= ended_nxt;
      speech_run_r  <= speech_run_nxt;
      silence_run_r <= silence_run_nxt;
      head_r        <= head_nxt;
      fill_r        <= fill_nxt;
      pspeech_r     <= pspeech_nxt;
      utt_frames_r  <= utt_frames_nxt;
      utt_speech_r  <= utt_speech_nxt;
      utt_start_r   <= utt_start_nxt;
      frame_index_r <= frame_index_nxt;
      next_id_r     <= next_id_nxt;
      fwd_hit_r     <= ram_we && (ram_waddr == head_nxt);
      fwd_data_r    <= ram_wdata;
      cnt_r         <= cnt_nxt;
    end
  end

  // output queue payload
  always_ff @(posedge clk) begin
    if (pop && cnt_r == 2'd2) begin
      slot0_r <= slot1_r;
      if (push) begin
        slot1_r <= res;
      end
    end else if (pop) begin
      if (push) begin
        slot0_r <= res;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        slot0_r <= res;
      end else begin
        slot1_r <= res;
      end
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tuser  = {slot0_r.close_reason, slot0_r.kept};
  assign out_tdata  = {slot0_r.speech_count, slot0_r.frame_total, slot0_r.end_frame,
                       slot0_r.start_frame, slot0_r.utt_id};

  always_comb begin
    case (cfg_paddr[4:2])
      vus_pkg::REG_START_RUN:     cfg_prdata = 32'(start_run_r);
      vus_pkg::REG_PREROLL:       cfg_prdata = 32'(preroll_frames_r);
      vus_pkg::REG_SILENCE_CLOSE: cfg_prdata = 32'(silence_close_r);
      vus_pkg::REG_MIN_SPEECH:    cfg_prdata = 32'(min_speech_r);
      vus_pkg::REG_MAX_LENGTH:    cfg_prdata = 32'(max_length_r);
      default:                    cfg_prdata = 32'd0;
    endcase
  end

  assign cfg_pready = 1'b1;

  // assertions
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("output queue count out of range");

  a_no_result_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |-> !push)
    else $error("result produced after end of stream");

  a_ring_empty_in_utt: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r != MODE_IDLE) |-> (fill_r == '0 && pspeech_r == '0))
    else $error("pre-roll ring not empty during an utterance");

  a_ring_speech_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (pspeech_r <= fill_r) && (fill_r <= FW'(PREROLL_DEPTH)))
    else $error("pre-roll speech count exceeds fill");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> out_tvalid)
    else $error("pushed result not presented");

endmodule

/* tb/vus_segment_checker.sv */
`timescale 1ns / 1ps
// checker for the utterance segmenter: follows register writes, predicts every
// closed utterance from the accepted event beats and compares the result beats
// depends on vus_pkg

module vus_segment_checker #(
  parameter int DEPTH = vus_pkg::PREROLL_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  input  logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [0] speech flag
  input  logic [0:0]                 in_tuser,   // [0] cmd
  input  logic                       out_tvalid,
  input  logic                       out_tready,
  // [31:0] utt_id, [63:32] start_frame, [95:64] end_frame,
  // [111:96] frame_total, [127:112] speech_count
  input  logic [127:0]               out_tdata,
  input  logic [2:0]                 out_tuser,  // [0] kept, [2:1] close_reason
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic                       cfg_pready,
  input  logic [vus_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [vus_pkg::CFG_DW-1:0] cfg_pwdata,
  output int                         mismatches,
  output int                         pending
);

  typedef enum logic [1:0] {SEG_IDLE, SEG_SPEECH, SEG_ENDING} seg_mode_t;

  // register copies
  logic [6:0]  start_run;
  logic [6:0]  preroll_cap;
  logic [15:0] silence_close;
  logic [15:0] min_speech;
  logic [15:0] max_len;

  seg_mode_t   mode;
  logic        ended;
  logic [6:0]  speech_run;
  logic [15:0] silence_run;
  logic        ring_flags [DEPTH];
  logic [5:0]  ring_head;
  logic [6:0]  ring_fill;
  logic [6:0]  ring_speech;
  logic [15:0] utt_frames;
  logic [15:0] utt_speech;
  logic [31:0] utt_start;
  logic [31:0] frame_idx;
  logic [31:0] next_id;

  vus_pkg::result_t utt_expected [$];
  int          fail_count = 0;

  function automatic string utt_text(input vus_pkg::result_t r);
    return $sformatf("kept=%0d reason=%0d id=%0d start=%0d end=%0d frames=%0d speech=%0d",
                     r.kept, r.close_reason, r.utt_id, r.start_frame, r.end_frame,
                     r.frame_total, r.speech_count);
  endfunction

  task automatic clear_ring();
    ring_head   = '0;
    ring_fill   = '0;
    ring_speech = '0;
  endtask

  task automatic reset_model();
    start_run     = 7'd3;
    preroll_cap   = 7'd10;
    silence_close = 16'd25;
    min_speech    = 16'd10;
    max_len       = 16'd1500;
    mode          = SEG_IDLE;
    ended         = 1'b0;
    speech_run    = '0;
    silence_run   = '0;
    clear_ring();
    utt_frames  = '0;
    utt_speech  = '0;
    utt_start   = '0;
    frame_idx   = '0;
    next_id     = '0;
  endtask

  task automatic write_register(input logic [2:0] idx, input logic [31:0] value);
    case (idx)
      vus_pkg::REG_START_RUN:     start_run     = value[6:0];
      vus_pkg::REG_PREROLL:       preroll_cap   = value[6:0];
      vus_pkg::REG_SILENCE_CLOSE: silence_close = value[15:0];
      vus_pkg::REG_MIN_SPEECH:    min_speech    = value[15:0];
      vus_pkg::REG_MAX_LENGTH:    max_len       = value[15:0];
      default: ;
    endcase
  endtask

  // idle frames go into the pre-roll ring, oldest dropped once the capacity is reached
  task automatic ring_store(input logic flag);
    int cap;
    int idx;
    cap = (preroll_cap > DEPTH) ? DEPTH : int'(preroll_cap);
    if (int'(ring_fill) >= cap) begin
      if (ring_fill == 0) return;
      ring_speech = ring_speech - 7'(ring_flags[ring_head]);
      ring_head   = 6'((int'(ring_head) + 1) % DEPTH);
      ring_fill   = ring_fill - 7'd1;
    end
    idx = (int'(ring_head) + int'(ring_fill)) % DEPTH;
    ring_flags[idx] = flag;
    ring_fill   = ring_fill + 7'd1;
    ring_speech = ring_speech + 7'(flag);
  endtask

  task automatic close_utterance(input logic [1:0] reason);
    vus_pkg::result_t r;
    logic    keep;
    keep           = (utt_speech >= min_speech);
    r.kept         = keep;
    r.close_reason = reason;
    r.utt_id       = keep ? next_id : 32'd0;
    r.start_frame  = utt_start;
    r.end_frame    = frame_idx - 32'd1;
    r.frame_total  = utt_frames;
    r.speech_count = utt_speech;
    utt_expected = {utt_expected, r};
    if (keep) next_id = next_id + 32'd1;
    utt_frames  = '0;
    utt_speech  = '0;
    silence_run = '0;
    speech_run  = '0;
    clear_ring();
    mode = SEG_IDLE;
  endtask

  task automatic segment_event(input logic eos, input logic speech);
    logic [6:0]  need;
    logic [31:0] cur;
    if (ended) return;
    if (eos) begin
      ended = 1'b1;
      if (mode != SEG_IDLE) close_utterance(vus_pkg::REASON_EOS);
      return;
    end
    cur       = frame_idx;
    frame_idx = frame_idx + 32'd1;

    if (mode == SEG_IDLE) begin
      need = (start_run == 0) ? 7'd1 : start_run;
      if (speech) begin
        if (speech_run < vus_pkg::RUN_MAX) speech_run = speech_run + 7'd1;
      end else begin
        speech_run = '0;
      end
      if (speech_run >= need) begin
        // utterance opens with the whole pre-roll plus this frame
        utt_start   = cur - 32'(ring_fill);
        utt_frames  = 16'(ring_fill) + 16'd1;
        utt_speech  = 16'(ring_speech) + 16'd1;
        clear_ring();
        speech_run  = '0;
        silence_run = '0;
        mode        = SEG_SPEECH;
        if (utt_frames >= max_len) close_utterance(vus_pkg::REASON_MAX_LEN);
      end else begin
        ring_store(speech);
      end
      return;
    end

    if (utt_frames < vus_pkg::CNT16_MAX) utt_frames = utt_frames + 16'd1;
    if (speech && utt_speech < vus_pkg::CNT16_MAX) utt_speech = utt_speech + 16'd1;
    if (speech) begin
      silence_run = '0;
      mode        = SEG_SPEECH;
    end else begin
      if (mode == SEG_SPEECH) silence_run = 16'd1;
      else if (silence_run < vus_pkg::CNT16_MAX) silence_run = silence_run + 16'd1;
      mode = SEG_ENDING;
      // end silence takes precedence over max length on the same frame
      if (silence_run >= silence_close) begin
        close_utterance(vus_pkg::REASON_SILENCE);
        return;
      end
    end
    if (utt_frames >= max_len) close_utterance(vus_pkg::REASON_MAX_LEN);
  endtask

  task automatic check_result(input vus_pkg::result_t got);
    vus_pkg::result_t want;
    if (utt_expected.size() == 0) begin
      fail_count++;
      if (fail_count <= 10) $display("unexpected result beat: %s", utt_text(got));
      return;
    end
    want = utt_expected[0];
    utt_expected.delete(0);
    if (got.kept !== want.kept || got.close_reason !== want.close_reason ||
        got.utt_id !== want.utt_id || got.start_frame !== want.start_frame ||
        got.end_frame !== want.end_frame || got.frame_total !== want.frame_total ||
        got.speech_count !== want.speech_count) begin
      fail_count++;
      if (fail_count <= 10) begin
        $display("result mismatch at %0t", $realtime);
        $display("  expected %s", utt_text(want));
        $display("  actual   %s", utt_text(got));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
      utt_expected.delete();
    end else begin
      if (out_tvalid && out_tready)
        check_result(vus_pkg::result_t'({out_tdata, out_tuser}));
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)
        write_register(cfg_paddr[4:2], cfg_pwdata);
      if (in_tvalid && in_tready) segment_event(in_tuser[0], in_tdata[0]);
    end
    pending    <= utt_expected.size();
    mismatches <= fail_count;
  end

endmodule

/* tb/tb_vad_utterance_segmenter.sv */
`timescale 1ns / 1ps
// top of the segmenter testbench: clock, reset, register setup and event stimulus
// depends on vus_pkg, vad_utterance_segmenter and vus_segment_checker

module tb_vad_utterance_segmenter;

  localparam logic EV_FRAME = 1'b0;
  localparam logic EV_EOS   = 1'b1;

  typedef struct {
    int start_run;
    int preroll;
    int silence_close;
    int min_speech;
    int max_len;
    int idle_pct;
    int stall_pct;
    int n_items;
  } seg_phase_t;

  logic                clk;
  logic                rst_n;
  logic                in_tvalid;
  logic                in_tready;
  logic [7:0]          in_tdata;   // [0] speech flag
  logic [0:0]          in_tuser;   // [0] cmd
  logic                out_tvalid;
  logic                out_tready = 1'b1;
  // [31:0] utt_id, [63:32] start_frame, [95:64] end_frame,
  // [111:96] frame_total, [127:112] speech_count
  logic [127:0]        out_tdata;
  logic [2:0]          out_tuser;  // [0] kept, [2:1] close_reason
  logic                cfg_psel;
  logic                cfg_penable;
  logic                cfg_pwrite;
  logic [vus_pkg::CFG_AW-1:0] cfg_paddr;
  logic [vus_pkg::CFG_DW-1:0] cfg_pwdata;
  logic [vus_pkg::CFG_DW-1:0] cfg_prdata;
  logic                cfg_pready;

  int mismatches;
  int pending;
  int idle_pct   = 0;
  int stall_pct  = 0;
  int items_sent = 0;
  int cur_need;
  int cur_preroll;
  int cur_end;

  vad_utterance_segmenter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  vus_segment_checker chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_pready (cfg_pready),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic int cap_len(input int a, input int b);
    return (a < b) ? a : b;
  endfunction

  task automatic send_event(input logic cmd, input logic speech);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, speech};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_run(input logic speech, input int len);
    repeat (len) send_event(EV_FRAME, speech);
  endtask

  // hold off until every outstanding utterance has been reported
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input int value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apply_phase(input seg_phase_t p);
    cfg_write(vus_pkg::REG_START_RUN, p.start_run);
    cfg_write(vus_pkg::REG_PREROLL, p.preroll);
    cfg_write(vus_pkg::REG_SILENCE_CLOSE, p.silence_close);
    cfg_write(vus_pkg::REG_MIN_SPEECH, p.min_speech);
    cfg_write(vus_pkg::REG_MAX_LENGTH, p.max_len);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cur_need    = (p.start_run == 0) ? 1 : p.start_run;
    cur_preroll = p.preroll;
    cur_end     = p.silence_close;
    idle_pct    = p.idle_pct;
    stall_pct   = p.stall_pct;
  endtask

  // mostly silence / speech burst / mixed tail / closing silence, some noise and short speech runs
  task automatic random_stream(input int n_items);
    int target;
    int kind;
    target = items_sent + n_items;
    while (items_sent < target) begin
      kind = $urandom_range(9);
      if (kind == 0) begin
        send_event(EV_FRAME, 1'($urandom_range(1)));
      end else if (kind == 1) begin
        // speech run that stops short of the trigger when more than one speech frame is needed
        send_run(1'b1, $urandom_range((cur_need > 1) ? cur_need - 1 : 1, 1));
        send_run(1'b0, 1);
      end else begin
        send_run(1'b0, $urandom_range(cap_len(cur_preroll + 2, 12), 0));
        send_run(1'b1, $urandom_range(cur_need + 6, cur_need));
        repeat ($urandom_range(25)) send_event(EV_FRAME, $urandom_range(99) < 65);
        send_run(1'b0, $urandom_range(cap_len(cur_end + 1, 40), cap_len(cur_end - 1, 40)));
      end
      if ($urandom_range(19) == 0) drain();
    end
  endtask

  initial begin
    seg_phase_t  plan [5];
    seg_phase_t  opening;
    logic [27:0] directed_bits;

    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = EV_FRAME;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    rst_n       = 1'b0;

    opening = '{2, 3, 2, 3, 6, 0, 0, 0};
    // kept with both closes on one frame, discarded, max length,
    // speech back out of ending, then silence left in the pre-roll
    directed_bits = 28'b0010_1100_1100_1111_1101_0110_1000;

    plan[0] = '{1, 0, 1, 0, 1, 0, 0, 80};
    plan[1] = '{0, 100, 3, 4, 20, 71, 0, 90};
    plan[2] = '{5, 4, 6, 8, 60, 0, 71, 90};
    plan[3] = '{$urandom_range(8, 1), $urandom_range(64), $urandom_range(8, 1),
                $urandom_range(20), $urandom_range(100, 1), 38, 38, 90};
    plan[4] = '{64, 64, 65535, 65535, 65535, 38, 38, 60};

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    apply_phase(opening);
    for (int i = 27; i >= 0; i--) send_event(EV_FRAME, directed_bits[i]);

    for (int p = 0; p < 5; p++) begin
      drain();
      apply_phase(plan[p]);
      random_stream(plan[p].n_items);
    end

    // make sure an utterance is open, then close it by end of stream
    send_run(1'b1, cur_need);
    send_event(EV_EOS, 1'b0);
    // these are taken and ignored
    send_event(EV_FRAME, 1'b1);
    send_event(EV_EOS, 1'b1);
    send_event(EV_FRAME, 1'b0);
    drain();
    repeat (4) @(negedge clk);

    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
